// ===== design/assert_macros.svh =====
// Assertion helpers shared by the RTL.
// Every property is sampled on clk_i; ASSERT_CLK properties are ignored while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is checked only outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Assertion that is also checked while reset is asserted.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== design/mrsp_pkg.sv =====
package mrsp_pkg;

  // Status byte ranges
  localparam logic [7:0] VoiceHigh  = 8'hEF;
  localparam logic [7:0] CommonHigh = 8'hF7;

  // Message lengths
  localparam logic [1:0] LenNone  = 2'd0;
  localparam logic [1:0] LenShort = 2'd2;
  localparam logic [1:0] LenLong  = 2'd3;

  // Bytes held in the open message
  localparam logic [1:0] HeldNone   = 2'd0;
  localparam logic [1:0] HeldStatus = 2'd1;
  localparam logic [1:0] HeldFirst  = 2'd2;

  // Message length by status high nibble
  localparam logic [1:0] LenByNibble [16] = '{
    LenNone, LenNone, LenNone, LenNone, LenNone, LenNone, LenNone, LenNone,
    LenLong, LenLong, LenLong, LenLong, LenShort, LenShort, LenLong, LenNone
  };

  typedef enum logic [1:0] {
    KindData,
    KindVoice,
    KindCommon,
    KindRealtime
  } byte_kind_e;

  // One completed voice message
  typedef struct packed {
    logic [1:0] message_length;
    logic [6:0] second_data;
    logic [6:0] first_data;
    logic [7:0] status_byte;
  } msg_t;

  function automatic logic [1:0] len_of(input logic [7:0] status);
    return LenByNibble[status[7:4]];
  endfunction

  function automatic byte_kind_e kind_of(input logic [7:0] b);
    byte_kind_e k;
    if (!b[7]) begin
      k = KindData;
    end else if (b <= VoiceHigh) begin
      k = KindVoice;
    end else if (b <= CommonHigh) begin
      k = KindCommon;
    end else begin
      k = KindRealtime;
    end
    return k;
  endfunction

endpackage

// ===== design/mrsp_in_reg.sv =====
// Input register slice: holds one received byte until the parser takes it.
module mrsp_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  logic [7:0] byte_i,
  output logic       valid_o,
  output logic [7:0] byte_o,
  input  logic       take_i
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       load;

  // Free when empty or when the held word leaves this cycle
  assign ready_o = !valid_q || take_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

// ===== design/mrsp_parser.sv =====
`include "assert_macros.svh"

// Running-status parser: one byte per take; the result is combinational and the state is registered on each take.
module mrsp_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          take_i,
  input  logic [7:0]    byte_i,
  output logic          res_valid_o,
  output mrsp_pkg::msg_t res_o
);

  logic [7:0] status_q, status_d;
  logic [1:0] exp_len_q, exp_len_d;
  logic [1:0] held_q, held_d;
  logic [6:0] first_q, first_d;

  logic [1:0] eff_len;
  logic       open_new;

  // Next state and result for the byte being taken
  always_comb begin
    status_d    = status_q;
    exp_len_d   = exp_len_q;
    held_d      = held_q;
    first_d     = first_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    open_new    = (held_q == mrsp_pkg::HeldNone);
    eff_len     = open_new ? mrsp_pkg::len_of(status_q) : exp_len_q;

    unique case (mrsp_pkg::kind_of(byte_i))
      mrsp_pkg::KindData: begin
        if (status_q != '0) begin
          res_o.status_byte = status_q;
          exp_len_d = eff_len;
          if (open_new || held_q == mrsp_pkg::HeldStatus) begin
            if (eff_len == mrsp_pkg::LenShort) begin
              res_valid_o          = 1'b1;
              res_o.first_data     = byte_i[6:0];
              res_o.message_length = mrsp_pkg::LenShort;
              held_d               = mrsp_pkg::HeldNone;
            end else begin
              first_d = byte_i[6:0];
              held_d  = mrsp_pkg::HeldFirst;
            end
          end else begin
            res_valid_o          = 1'b1;
            res_o.first_data     = first_q;
            res_o.second_data    = byte_i[6:0];
            res_o.message_length = mrsp_pkg::LenLong;
            held_d               = mrsp_pkg::HeldNone;
          end
        end
      end
      mrsp_pkg::KindVoice: begin
        status_d  = byte_i;
        exp_len_d = mrsp_pkg::len_of(byte_i);
        held_d    = mrsp_pkg::HeldStatus;
      end
      mrsp_pkg::KindCommon: begin
        status_d = '0;
        held_d   = mrsp_pkg::HeldNone;
      end
      mrsp_pkg::KindRealtime: begin
        // ignored, open message stays
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q  <= '0;
      exp_len_q <= mrsp_pkg::LenNone;
      held_q    <= mrsp_pkg::HeldNone;
      first_q   <= '0;
    end else if (take_i) begin
      status_q  <= status_d;
      exp_len_q <= exp_len_d;
      held_q    <= held_d;
      first_q   <= first_d;
    end
  end

  // Checks
  `ASSERT_ALWAYS(a_open_has_status,
    held_q != mrsp_pkg::HeldNone |-> status_q != '0,
    "message open without running status")
  `ASSERT_CLK(a_emit_closes,
    take_i && res_valid_o |=> held_q == mrsp_pkg::HeldNone,
    "message still open after it was emitted")
  `ASSERT_CLK(a_emit_status_range,
    res_valid_o |-> res_o.status_byte[7] && res_o.status_byte <= mrsp_pkg::VoiceHigh,
    "emitted status outside voice range")
  `ASSERT_CLK(a_short_no_second,
    res_valid_o && res_o.message_length == mrsp_pkg::LenShort |-> res_o.second_data == '0,
    "two-byte message carries second data")

endmodule

// ===== design/mrsp_out_reg.sv =====
// Output register: holds one message until the sink takes it.
module mrsp_out_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  mrsp_pkg::msg_t msg_i,
  output logic           free_o,
  output logic           valid_o,
  input  logic           ready_i,
  output mrsp_pkg::msg_t msg_o
);

  logic           valid_q, valid_d;
  mrsp_pkg::msg_t msg_q;

  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      msg_q <= msg_i;
    end
  end

  assign valid_o = valid_q;
  assign msg_o   = msg_q;

endmodule

// ===== design/midi_running_status_parser.sv =====
// MIDI running-status parser. Raw MIDI bytes go in on the slave stream, one
// per word; each complete channel voice message comes out on the master stream
// as one word. Status bytes 0x80-0xEF open a message and set running status,
// data bytes complete it (reusing running status when no message is open),
// 0xF0-0xF7 clear running status and drop a partial message, and real-time
// bytes 0xF8-0xFF are ignored. One byte is accepted every cycle while the sink
// keeps up. A message is offered on the master stream after its last byte has
// been held in the input register slice and the combinational parser has
// written its result straight into the output register.
// A stalled sink holds the output register and, through it, the input.
module midi_running_status_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] midi_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // [7:0] status_byte, [14:8] first_data,
                                      // [21:15] second_data, [23:22] message_length
);

  logic           in_valid;
  logic [7:0]     in_byte;
  logic           take;
  logic           out_free;
  logic           res_valid;
  mrsp_pkg::msg_t res;
  mrsp_pkg::msg_t out_msg;

  // A byte moves through the parser only when the result slot can take it
  assign take = in_valid && out_free;

  mrsp_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .byte_i  (s_axis_tdata),
    .valid_o (in_valid),
    .byte_o  (in_byte),
    .take_i  (take)
  );

  mrsp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .byte_i      (in_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  mrsp_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (take && res_valid),
    .msg_i   (res),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .msg_o   (out_msg)
  );

  assign m_axis_tdata = out_msg;

endmodule
